### hdl/ctse_pkg.sv
// Shared types, codes and default sizes for the card table scan engine.
package ctse_pkg;

    localparam int CARD_SHIFT_DEF     = 7;
    localparam int NUM_CARDS_DEF      = 4096;
    localparam int MAX_SCAN_CARDS_DEF = 126;

    localparam int ADDR_W   = 48;
    localparam int SPAN_W   = 14;
    localparam int CMD_W    = 3;
    localparam int KIND_W   = 3;
    localparam int COUNT_W  = 13;
    localparam int STATE_W  = 2;
    localparam int CFG_IDX_W = 1;

    // commands
    localparam logic [CMD_W-1:0] CMD_MARK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SCAN  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 3'd2;
    localparam logic [CMD_W-1:0] CMD_AGE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_RUN   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COUNT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR = 3'd4;

    // card states
    localparam logic [STATE_W-1:0] ST_UNMARKED  = 2'd0;
    localparam logic [STATE_W-1:0] ST_MARKED    = 2'd1;
    localparam logic [STATE_W-1:0] ST_UNTOUCHED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTECTED_CARDS = 1'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [SPAN_W-1:0] span_bytes;
    } cmd_word_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  run_begin;
        logic [ADDR_W:0]    run_end;
        logic               any_marked;
        logic [COUNT_W-1:0] changed_count;
        logic               last;
    } rsp_word_t;

endpackage

### hdl/ctse_card_mem.sv
// Card state memory: one write port, one registered read port.
module ctse_card_mem
    import ctse_pkg::*;
#(
    parameter int NUM_CARDS = NUM_CARDS_DEF,
    parameter int IDX_W     = (NUM_CARDS > 1) ? $clog2(NUM_CARDS) : 1
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [STATE_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [STATE_W-1:0] rd_data
);

    logic [STATE_W-1:0] mem [NUM_CARDS];
    logic [STATE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/card_table_scan_engine.sv
// Card table scan engine top level: command sequencer, output register, card memory.
//
// The engine keeps one 2-bit state per card in a single-port-write, registered-read
// memory. After reset it sweeps the memory to unmarked, one card per cycle, before
// the first command word is accepted; configuration writes are taken at any time.
// Scan and query walk the cards of the span one per cycle through the memory read
// port; a scan may also pause while a run word waits at the output. Age and clear
// walk the table from protected_cards to the end, one read-modify-write per cycle.
// One command is worked on at a time; the next command word is accepted as soon as
// the previous one has handed its final word, if any, to the output register, even
// if that word is still stalled.
module card_table_scan_engine
    import ctse_pkg::*;
#(
    parameter int CARD_SHIFT     = CARD_SHIFT_DEF,
    parameter int NUM_CARDS      = NUM_CARDS_DEF,
    parameter int MAX_SCAN_CARDS = MAX_SCAN_CARDS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  cmd_word_t            cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_word_t            rsp
);

    localparam int IDX_W = (NUM_CARDS > 1) ? $clog2(NUM_CARDS) : 1;
    localparam logic [63:0] REGION_BYTES = 64'(NUM_CARDS) << CARD_SHIFT;
    localparam logic [31:0] MAX_SPAN = 32'(MAX_SCAN_CARDS) << CARD_SHIFT;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CARDS - 1);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_WALK   = 4'd4;
    localparam logic [3:0] S_AGE    = 4'd5;
    localparam logic [3:0] S_FINISH = 4'd6;
    localparam logic [3:0] S_FLUSH  = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    logic [3:0]         state_reg, state_next;
    cmd_word_t          cmd_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [COUNT_W-1:0] prot_reg;
    logic [ADDR_W:0]    off_reg, off_next;
    logic [ADDR_W:0]    end_reg, end_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic               in_run_reg, in_run_next;
    logic [IDX_W-1:0]   rs_reg, rs_next;
    logic               have_pend_reg, have_pend_next;
    logic [ADDR_W-1:0]  pend_b_reg, pend_b_next;
    logic [ADDR_W:0]    pend_e_reg, pend_e_next;
    logic               any_reg, any_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    rsp_word_t          res_reg, res_next;
    logic               rsp_valid_reg;
    rsp_word_t          rsp_reg;

    // memory port
    logic               wr_en, rd_en;
    logic [IDX_W-1:0]   wr_addr, rd_addr;
    logic [STATE_W-1:0] wr_data, rd_data;

    // output staging
    logic               out_free, out_load;
    rsp_word_t          out_next;

    // range checks and run clipping
    logic [ADDR_W:0]    last_off;
    logic               span_bad, below_base, mark_oob, span_oob;
    logic               marked, is_scan, close_run, advance, hit, is_age;
    logic [IDX_W:0]     close_e;
    logic [ADDR_W:0]    rb_full, re_full;
    logic [ADDR_W-1:0]  clip_b;
    logic [ADDR_W:0]    clip_e;
    rsp_word_t          pend_word;

    ctse_card_mem #(
        .NUM_CARDS (NUM_CARDS),
        .IDX_W     (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign last_off   = off_reg + (ADDR_W+1)'(cmd_reg.span_bytes) - (ADDR_W+1)'(1);
    assign below_base = off_reg[ADDR_W];
    assign mark_oob   = 64'(off_reg[ADDR_W-1:0]) >= REGION_BYTES;
    assign span_bad   = (cmd_reg.span_bytes == '0) || (32'(cmd_reg.span_bytes) > MAX_SPAN);
    assign span_oob   = 64'(last_off) >= REGION_BYTES;

    assign marked    = (rd_data != ST_UNMARKED);
    assign is_scan   = (cmd_reg.command == CMD_SCAN);
    assign is_age    = (cmd_reg.command == CMD_AGE);
    assign close_run = is_scan && in_run_reg && !marked;
    assign advance   = !(close_run && have_pend_reg) || out_free;
    assign hit       = is_age ? (rd_data == ST_MARKED) : (rd_data == ST_UNTOUCHED);

    // run end card: the current card mid-walk, one past the span's last card at the end
    assign close_e = (state_reg == S_FINISH) ? ((IDX_W+1)'(j_reg) + (IDX_W+1)'(1))
                                             : (IDX_W+1)'(cur_reg);
    assign rb_full = (ADDR_W+1)'(base_reg) + ((ADDR_W+1)'(rs_reg) << CARD_SHIFT);
    assign re_full = (ADDR_W+1)'(base_reg) + ((ADDR_W+1)'(close_e) << CARD_SHIFT);
    assign clip_b  = (rb_full < (ADDR_W+1)'(cmd_reg.address)) ? cmd_reg.address
                                                               : rb_full[ADDR_W-1:0];
    assign clip_e  = (re_full > end_reg) ? end_reg : re_full;

    always_comb
    begin
        pend_word           = '0;
        pend_word.kind      = KIND_RUN;
        pend_word.run_begin = pend_b_reg;
        pend_word.run_end   = pend_e_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        off_next       = off_reg;
        end_next       = end_reg;
        j_next         = j_reg;
        cur_next       = cur_reg;
        in_run_next    = in_run_reg;
        rs_next        = rs_reg;
        have_pend_next = have_pend_reg;
        pend_b_next    = pend_b_reg;
        pend_e_next    = pend_e_reg;
        any_next       = any_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_load       = 1'b0;
        out_next       = pend_word;
        wr_en          = 1'b0;
        wr_addr        = cur_reg;
        wr_data        = ST_UNMARKED;
        rd_en          = 1'b0;
        rd_addr        = cur_reg;

        case (state_reg)
            S_INIT:
            begin
                // sweep the table to unmarked after reset
                wr_en    = 1'b1;
                cur_next = cur_reg + IDX_W'(1);
                if (cur_reg == LAST_IDX)
                begin
                    cur_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                off_next   = (ADDR_W+1)'(cmd_reg.address) - (ADDR_W+1)'(base_reg);
                end_next   = (ADDR_W+1)'(cmd_reg.address) + (ADDR_W+1)'(cmd_reg.span_bytes);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                in_run_next    = 1'b0;
                have_pend_next = 1'b0;
                any_next       = 1'b0;
                cnt_next       = '0;
                res_next       = '0;
                res_next.last  = 1'b1;
                res_next.kind  = KIND_ERROR;
                state_next     = S_EMIT;
                case (cmd_reg.command)
                    CMD_MARK:
                    begin
                        if (!below_base && !mark_oob)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = IDX_W'(off_reg[ADDR_W-1:0] >> CARD_SHIFT);
                            wr_data    = ST_MARKED;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_SCAN, CMD_QUERY:
                    begin
                        if (!span_bad && !below_base && !span_oob)
                        begin
                            cur_next   = IDX_W'(off_reg[ADDR_W-1:0] >> CARD_SHIFT);
                            j_next     = IDX_W'(last_off[ADDR_W-1:0] >> CARD_SHIFT);
                            rd_en      = 1'b1;
                            rd_addr    = cur_next;
                            state_next = S_WALK;
                        end
                    end
                    CMD_AGE, CMD_CLEAR:
                    begin
                        if (32'(prot_reg) >= 32'(NUM_CARDS))
                        begin
                            res_next.kind = KIND_COUNT;
                        end
                        else
                        begin
                            cur_next   = IDX_W'(prot_reg);
                            rd_en      = 1'b1;
                            rd_addr    = cur_next;
                            state_next = S_AGE;
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_WALK:
            begin
                if (advance)
                begin
                    any_next = any_reg | marked;
                    if (close_run)
                    begin
                        // a finished run displaces the held one, which is not last
                        out_load       = have_pend_reg;
                        pend_b_next    = clip_b;
                        pend_e_next    = clip_e;
                        have_pend_next = 1'b1;
                        in_run_next    = 1'b0;
                    end
                    else if (marked && !in_run_reg)
                    begin
                        in_run_next = 1'b1;
                        rs_next     = cur_reg;
                    end
                    if (cur_reg == j_reg)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cur_next = cur_reg + IDX_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = cur_next;
                    end
                end
            end
            S_FINISH:
            begin
                if (!is_scan)
                begin
                    res_next.kind       = KIND_QUERY;
                    res_next.any_marked = any_reg;
                    state_next          = S_EMIT;
                end
                else if (!in_run_reg)
                begin
                    state_next = S_FLUSH;
                end
                else if (!have_pend_reg || out_free)
                begin
                    out_load       = have_pend_reg;
                    pend_b_next    = clip_b;
                    pend_e_next    = clip_e;
                    have_pend_next = 1'b1;
                    in_run_next    = 1'b0;
                    state_next     = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (have_pend_reg)
                    begin
                        out_next.last = 1'b1;
                    end
                    else
                    begin
                        out_next      = '0;
                        out_next.kind = KIND_NONE;
                        out_next.last = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_AGE:
            begin
                wr_en    = hit;
                wr_data  = is_age ? ST_UNTOUCHED : ST_UNMARKED;
                cnt_next = cnt_reg + COUNT_W'(hit);
                if (cur_reg == LAST_IDX)
                begin
                    res_next.kind          = KIND_COUNT;
                    res_next.changed_count = cnt_next;
                    state_next             = S_EMIT;
                end
                else
                begin
                    cur_next = cur_reg + IDX_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = cur_next;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_next   = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cur_reg       <= '0;
            in_run_reg    <= 1'b0;
            have_pend_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            base_reg      <= '0;
            prot_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            in_run_reg    <= in_run_next;
            have_pend_reg <= have_pend_next;
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_we && cfg_index == CFG_REGION_BASE)
            begin
                base_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_PROTECTED_CARDS)
            begin
                prot_reg <= cfg_data[COUNT_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
        if (out_load)
        begin
            rsp_reg <= out_next;
        end
        off_reg    <= off_next;
        end_reg    <= end_next;
        j_reg      <= j_next;
        rs_reg     <= rs_next;
        pend_b_reg <= pend_b_next;
        pend_e_reg <= pend_e_next;
        any_reg    <= any_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
    end

`ifndef SYNTHESIS
    a_walk_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (cur_reg <= j_reg))
        else $error("scan walk passed the span's last card");

    a_age_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AGE && wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("age write and read hit the same card");

    a_last_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_next.last) |=> (state_reg == S_IDLE))
        else $error("final word loaded but command still active");

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output register overwritten while stalled");
`endif

endmodule

### tb/card_table_scan_engine_tb.sv
// Self-checking testbench for the card table scan engine: directed and random command words.
`timescale 1ns / 1ps

module card_table_scan_engine_tb;
    import ctse_pkg::*;

    localparam int  CARDS        = 4096;
    localparam int  SHIFT        = 7;
    localparam int  SCAN_LIMIT   = 126;
    localparam logic [63:0] REGION_BYTES = 64'(CARDS) << SHIFT;
    localparam int  CYCLE_LIMIT  = 3000000;
    localparam int  HOLD_CYCLES  = 400;
    localparam logic [47:0] ADDR_TOP = 48'hFFFF_FFFF_FFFF;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;
    logic                 cmd_valid;
    logic                 cmd_stall;
    cmd_word_t            cmd;
    logic                 rsp_valid;
    logic                 rsp_stall;
    rsp_word_t            rsp;

    card_table_scan_engine uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    // shadow of the card memory and the registers
    logic [STATE_W-1:0] card_mem [CARDS];
    logic [ADDR_W-1:0]  base_reg;
    logic [COUNT_W-1:0] guard_reg;

    cmd_word_t pending_words [$];
    rsp_word_t expected_words [$];

    int   error_count;
    int   cycle_count;
    int   src_gap;
    int   rsp_burst;
    int   hold_left;
    int   hold_ask;
    int   hold_seen;
    bit   quiet;
    int   hot;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %0h, want %0h", what, got, want);
        error_count++;
    endtask

    function automatic rsp_word_t make_rsp(input logic [KIND_W-1:0] kind, input logic [63:0] rb,
                                          input logic [63:0] re, input logic any,
                                          input int cnt, input logic last);
        rsp_word_t r;
        r.kind          = kind;
        r.run_begin     = rb[ADDR_W-1:0];
        r.run_end       = re[ADDR_W:0];
        r.any_marked    = any;
        r.changed_count = cnt[COUNT_W-1:0];
        r.last          = last;
        return r;
    endfunction

    // Work out the result words of one accepted command and update the shadow memory.
    task automatic predict_results(input cmd_word_t w);
        logic [63:0] addr, span, base, off, i, j, fin, k, rb, re;
        logic        any;
        int          cnt;
        rsp_word_t   runs [$];
        addr = 64'(w.address);
        span = 64'(w.span_bytes);
        base = 64'(base_reg);
        case (w.command)
            CMD_MARK:
            begin
                if (addr < base || addr - base >= REGION_BYTES)
                    expected_words.push_back(make_rsp(KIND_ERROR, 0, 0, 0, 0, 1));
                else
                    card_mem[(addr - base) >> SHIFT] = ST_MARKED;
            end
            CMD_SCAN, CMD_QUERY:
            begin
                off = addr - base;
                if (span == 0 || span > (64'(SCAN_LIMIT) << SHIFT) || addr < base
                        || off + span > REGION_BYTES)
                begin
                    expected_words.push_back(make_rsp(KIND_ERROR, 0, 0, 0, 0, 1));
                end
                else
                begin
                    i   = off >> SHIFT;
                    j   = (off + span - 1) >> SHIFT;
                    fin = addr + span;
                    if (w.command == CMD_QUERY)
                    begin
                        any = 1'b0;
                        for (k = i; k <= j; k++)
                            if (card_mem[k] != ST_UNMARKED) any = 1'b1;
                        expected_words.push_back(make_rsp(KIND_QUERY, 0, 0, any, 0, 1));
                    end
                    else
                    begin
                        // walk maximal runs of marked cards, clip each to the span
                        while (i <= j)
                        begin
                            if (card_mem[i] == ST_UNMARKED)
                            begin
                                i++;
                                continue;
                            end
                            k = i;
                            while (i <= j && card_mem[i] != ST_UNMARKED) i++;
                            rb = base + (k << SHIFT);
                            re = base + (i << SHIFT);
                            if (rb < addr) rb = addr;
                            if (re > fin) re = fin;
                            if (runs.size() < 64) runs.push_back(make_rsp(KIND_RUN, rb, re, 0, 0, 0));
                        end
                        if (runs.size() == 0)
                            expected_words.push_back(make_rsp(KIND_NONE, 0, 0, 0, 0, 1));
                        else
                        begin
                            runs[runs.size()-1].last = 1'b1;
                            foreach (runs[n]) expected_words.push_back(runs[n]);
                        end
                    end
                end
            end
            CMD_AGE, CMD_CLEAR:
            begin
                cnt = 0;
                for (int c = int'(guard_reg); c < CARDS; c++)
                begin
                    if (w.command == CMD_AGE && card_mem[c] == ST_MARKED)
                    begin
                        card_mem[c] = ST_UNTOUCHED;
                        cnt++;
                    end
                    else if (w.command == CMD_CLEAR && card_mem[c] == ST_UNTOUCHED)
                    begin
                        card_mem[c] = ST_UNMARKED;
                        cnt++;
                    end
                end
                expected_words.push_back(make_rsp(KIND_COUNT, 0, 0, 0, cnt, 1));
            end
            default:
                expected_words.push_back(make_rsp(KIND_ERROR, 0, 0, 0, 0, 1));
        endcase
    endtask

    // Command driver: offer words from the pending queue, with random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
                predict_results(cmd);
            if (!cmd_valid || !cmd_stall)
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    cmd_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    cmd <= pending_words.pop_front();
                    cmd_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 3) == 0)
                        src_gap <= $urandom_range(1, 18);
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall: compare each word with the oldest expectation.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        if (rsp_valid && !rsp_stall && rst_n)
        begin
            if (expected_words.size() == 0)
            begin
                report("unexpected word", 64'(rsp.kind), 0);
            end
            else
            begin
                rsp_word_t want;
                want = expected_words.pop_front();
                if (rsp.kind != want.kind) report("kind", rsp.kind, want.kind);
                if (rsp.run_begin != want.run_begin) report("run_begin", rsp.run_begin, want.run_begin);
                if (rsp.run_end != want.run_end) report("run_end", rsp.run_end, want.run_end);
                if (rsp.any_marked != want.any_marked)
                    report("any_marked", rsp.any_marked, want.any_marked);
                if (rsp.changed_count != want.changed_count)
                    report("changed_count", rsp.changed_count, want.changed_count);
                if (rsp.last != want.last) report("last", rsp.last, want.last);
            end
        end
        // a long hold-off lets the engine back up and stall its command side
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (hold_seen != hold_ask)
        begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (quiet)
        begin
            rsp_stall <= 1'b0;
        end
        else if (rsp_burst > 0)
        begin
            rsp_burst <= rsp_burst - 1;
        end
        else
        begin
            rsp_burst <= $urandom_range(1, 18);
            rsp_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    // Hold until every pending word is taken and every result is back, then let marks drain.
    task automatic wait_idle();
        do @(negedge clk);
        while (pending_words.size() != 0 || cmd_valid || expected_words.size() != 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_REGION_BASE) base_reg = data;
        else guard_reg = data[COUNT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic cmd_word_t word_of(input logic [CMD_W-1:0] c, input logic [63:0] a,
                                         input int s);
        cmd_word_t w;
        w.command    = c;
        w.address    = a[ADDR_W-1:0];
        w.span_bytes = s[SPAN_W-1:0];
        return w;
    endfunction

    function automatic logic [63:0] card_addr(input int card);
        return 64'(base_reg) + (64'(card) << SHIFT) + 64'($urandom_range(0, 127));
    endfunction

    // Random word: mostly marks and scans around a hot window, some table sweeps and noise.
    function automatic cmd_word_t random_word();
        cmd_word_t w;
        int        sel;
        int        span;
        sel  = $urandom_range(0, 99);
        span = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 2000) : $urandom_range(1, 16128);
        w    = word_of(CMD_MARK, card_addr(hot + $urandom_range(0, 160)), span);
        if (sel < 45)
            w.command = CMD_MARK;
        else if (sel < 65)
            w.command = CMD_SCAN;
        else if (sel < 75)
            w.command = CMD_QUERY;
        else if (sel < 79)
            w.command = CMD_AGE;
        else if (sel < 82)
            w.command = CMD_CLEAR;
        else if (sel < 86)
        begin
            w.command    = ($urandom_range(0, 1) == 0) ? CMD_SCAN : CMD_QUERY;
            w.span_bytes = ($urandom_range(0, 1) == 0) ? '0 :
                           SPAN_W'($urandom_range(16129, 16383));
        end
        else
            w = word_of(CMD_W'($urandom_range(0, 7)), {$urandom, $urandom}, $urandom);
        return w;
    endfunction

    task automatic random_phase(input int count);
        hot = ($urandom_range(0, 4) == 0) ? CARDS - 150 : $urandom_range(0, CARDS - 161);
        repeat (count) pending_words.push_back(random_word());
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_REGION_BASE;
        cfg_data  <= '0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        rsp_stall <= 1'b0;
        error_count = 0;
        cycle_count = 0;
        src_gap     = 0;
        rsp_burst   = 0;
        hold_left   = 0;
        hold_ask    = 0;
        hold_seen   = 0;
        quiet       = 1'b0;
        base_reg    = '0;
        guard_reg   = '0;
        foreach (card_mem[c]) card_mem[c] = ST_UNMARKED;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: region edges, span limits, every command, unknown codes
        write_reg(CFG_REGION_BASE, '0);
        write_reg(CFG_PROTECTED_CARDS, '0);
        pending_words.push_back(word_of(CMD_MARK, 0, 1));
        pending_words.push_back(word_of(CMD_MARK, 127, 1));
        pending_words.push_back(word_of(CMD_MARK, REGION_BYTES - 1, 1));
        pending_words.push_back(word_of(CMD_MARK, REGION_BYTES, 1));
        pending_words.push_back(word_of(CMD_MARK, 64'(ADDR_TOP), 1));
        for (int c = 4; c < 40; c += 2)
            pending_words.push_back(word_of(CMD_MARK, 64'(c) << SHIFT, 1));
        pending_words.push_back(word_of(CMD_SCAN, 0, SCAN_LIMIT << SHIFT));
        pending_words.push_back(word_of(CMD_SCAN, 300, 1000));
        pending_words.push_back(word_of(CMD_SCAN, 0, (SCAN_LIMIT << SHIFT) + 1));
        pending_words.push_back(word_of(CMD_QUERY, 0, 0));
        pending_words.push_back(word_of(CMD_QUERY, REGION_BYTES - 1, 1));
        pending_words.push_back(word_of(CMD_QUERY, 200, 1));
        pending_words.push_back(word_of(CMD_SCAN, REGION_BYTES - 100, 200));
        pending_words.push_back(word_of(CMD_SCAN, 50000, 300));
        pending_words.push_back(word_of(CMD_AGE, 0, 1));
        pending_words.push_back(word_of(CMD_CLEAR, 0, 1));
        pending_words.push_back(word_of(3'd5, 0, 1));
        pending_words.push_back(word_of(3'd6, 0, 1));
        pending_words.push_back(word_of(3'd7, 0, 1));
        wait_idle();

        // top of the address space, protection covering the whole table
        write_reg(CFG_REGION_BASE, ADDR_TOP - 48'(REGION_BYTES) + 1);
        write_reg(CFG_PROTECTED_CARDS, COUNT_W'(CARDS));
        hot = CARDS - 150;
        repeat (8) pending_words.push_back(word_of(CMD_MARK, card_addr(hot + $urandom_range(0, 149)), 1));
        pending_words.push_back(word_of(CMD_SCAN, card_addr(hot), 16000));
        pending_words.push_back(word_of(CMD_AGE, 0, 1));
        pending_words.push_back(word_of(CMD_MARK, 64'(base_reg) - 1, 1));
        wait_idle();

        // unaligned base that overflows the address space
        write_reg(CFG_REGION_BASE, ADDR_TOP);
        write_reg(CFG_PROTECTED_CARDS, '0);
        pending_words.push_back(word_of(CMD_MARK, 64'(ADDR_TOP), 1));
        pending_words.push_back(word_of(CMD_SCAN, 64'(ADDR_TOP), 1));
        pending_words.push_back(word_of(CMD_QUERY, 64'(ADDR_TOP), 1));
        wait_idle();

        // random phases, each under a new setting; the second one holds off the receiver
        for (int p = 0; p < 4; p++)
        begin
            write_reg(CFG_REGION_BASE, ($urandom_range(0, 1) == 0) ?
                      ADDR_W'({$urandom, $urandom} & 64'h0000_7FFF_FFFF_FF80) : 48'($urandom));
            write_reg(CFG_PROTECTED_CARDS, ($urandom_range(0, 2) == 0) ? '0 :
                      COUNT_W'($urandom_range(0, CARDS)));
            if (p == 1) hold_ask++;
            random_phase(36);
            wait_idle();
        end

        // closing stretch without idling on either side
        quiet = 1'b1;
        random_phase(40);
        wait_idle();

        if (error_count == 0 && expected_words.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### card_table_scan_engine.f
hdl/ctse_pkg.sv
hdl/ctse_card_mem.sv
hdl/card_table_scan_engine.sv
tb/card_table_scan_engine_tb.sv
